[rtl/core/pfp_pkg.sv]
package pfp_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int FOOT_BITS      = 18;

endpackage

[rtl/core/pfp_in_if.sv]
interface pfp_in_if #(
  parameter int COORD_BITS = pfp_pkg::COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] line_a_x;
  logic signed [COORD_BITS-1:0] line_a_y;
  logic signed [COORD_BITS-1:0] line_b_x;
  logic signed [COORD_BITS-1:0] line_b_y;
  logic signed [COORD_BITS-1:0] query_x;
  logic signed [COORD_BITS-1:0] query_y;

  modport source (output valid, line_a_x, line_a_y, line_b_x, line_b_y, query_x, query_y,
                  input ready);
  modport sink   (input valid, line_a_x, line_a_y, line_b_x, line_b_y, query_x, query_y,
                  output ready);
endinterface

interface pfp_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [pfp_pkg::FOOT_BITS-1:0]  foot_x;
  logic signed [pfp_pkg::FOOT_BITS-1:0]  foot_y;
  logic                                  degenerate;

  modport source (output valid, foot_x, foot_y, degenerate, input ready);
  modport sink   (input valid, foot_x, foot_y, degenerate, output ready);
endinterface

[rtl/core/perpendicular_foot_point.sv]
// perpendicular_foot_point
// Projects query point Q onto the line through points A and B and returns
// the foot of the perpendicular, each coordinate truncated toward zero.
// Channels: in_ch (valid/ready) carries A, B and Q; out_ch (valid/ready)
// carries foot_x, foot_y and degenerate. Each input item yields one result.
// Pipeline: 6 arithmetic stages, 18 restoring-division stages producing one
// quotient bit each, and one output register. Throughput: one item per cycle
// while out_ch is not stalled; the multipliers and the division stages are
// fully pipelined.
// When A equals B, degenerate is 1 and both coordinates are 0. A quotient
// outside the 18-bit signed range saturates.
// Reset (rst_n low, synchronous) empties the pipeline; no result is pending
// afterward.
// Stall: while out_ch.ready is low and a result is held, the whole pipeline
// freezes and in_ch.ready drops; nothing is lost or repeated.
module perpendicular_foot_point #(
  parameter int COORD_BITS = pfp_pkg::COORD_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  pfp_in_if.sink              in_ch,
  pfp_out_if.source           out_ch
);

  localparam int N   = COORD_BITS;
  localparam int QB  = pfp_pkg::FOOT_BITS;
  localparam int DW  = 2*N + 2;
  localparam int MW  = 3*N + 3;
  localparam int NW  = 3*N + 4;
  localparam int RW  = (NW > DW + QB) ? NW : DW + QB;

  logic adv;
  assign adv = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = adv;

  // stage 1: differences
  logic signed [N-1:0] ax1_r, ay1_r, qx1_r, qy1_r;
  logic signed [N:0]   dx1_r, dy1_r;
  logic                v1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_ch.valid;
    end
    if (adv) begin
      ax1_r <= in_ch.line_a_x;
      ay1_r <= in_ch.line_a_y;
      qx1_r <= in_ch.query_x;
      qy1_r <= in_ch.query_y;
      dx1_r <= (N+1)'(in_ch.line_a_x) - (N+1)'(in_ch.line_b_x);
      dy1_r <= (N+1)'(in_ch.line_a_y) - (N+1)'(in_ch.line_b_y);
    end
  end

  // stage 2: first products
  logic signed [DW-1:0] p0_r, p1_r, p2_r, p3_r, dd0_r, dd1_r;
  logic signed [N:0]    dx2_r, dy2_r;
  logic                 deg2_r, v2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv) begin
      v2_r <= v1_r;
    end
    if (adv) begin
      p0_r   <= DW'(dy1_r * ax1_r);
      p1_r   <= DW'(dx1_r * ay1_r);
      p2_r   <= DW'(dx1_r * qx1_r);
      p3_r   <= DW'(dy1_r * qy1_r);
      dd0_r  <= DW'(dx1_r * dx1_r);
      dd1_r  <= DW'(dy1_r * dy1_r);
      dx2_r  <= dx1_r;
      dy2_r  <= dy1_r;
      deg2_r <= (dx1_r == '0) && (dy1_r == '0);
    end
  end

  // stage 3: c0, -c1, |d|^2
  logic signed [DW-1:0] c0_r, c1n_r;
  logic        [DW-1:0] den3_r;
  logic signed [N:0]    dx3_r, dy3_r;
  logic                 deg3_r, v3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (adv) begin
      v3_r <= v2_r;
    end
    if (adv) begin
      c0_r   <= p1_r - p0_r;
      c1n_r  <= p2_r + p3_r;
      den3_r <= DW'(dd0_r + dd1_r);
      dx3_r  <= dx2_r;
      dy3_r  <= dy2_r;
      deg3_r <= deg2_r;
    end
  end

  // stage 4: second products
  logic signed [MW-1:0] m0_r, m1_r, m2_r, m3_r;
  logic        [DW-1:0] den4_r;
  logic                 deg4_r, v4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (adv) begin
      v4_r <= v3_r;
    end
    if (adv) begin
      m0_r   <= MW'(c1n_r * dx3_r);
      m1_r   <= MW'(c0_r * dy3_r);
      m2_r   <= MW'(c0_r * dx3_r);
      m3_r   <= MW'(c1n_r * dy3_r);
      den4_r <= den3_r;
      deg4_r <= deg3_r;
    end
  end

  // stage 5: numerators
  logic signed [NW-1:0] numx_r, numy_r;
  logic        [DW-1:0] den5_r;
  logic                 deg5_r, v5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (adv) begin
      v5_r <= v4_r;
    end
    if (adv) begin
      numx_r <= NW'(m0_r) - NW'(m1_r);
      numy_r <= NW'(m2_r) + NW'(m3_r);
      den5_r <= den4_r;
      deg5_r <= deg4_r;
    end
  end

  // stage 6 (index 0 of division line): magnitude, sign, overflow
  logic [RW-1:0] remx_r [QB+1];
  logic [RW-1:0] remy_r [QB+1];
  logic [QB-1:0] qtx_r  [QB+1];
  logic [QB-1:0] qty_r  [QB+1];
  logic [DW-1:0] den_r  [QB+1];
  logic [QB:0]   negx_r, negy_r, ovfx_r, ovfy_r, deg_r, vd_r;

  logic [NW-1:0] magx, magy;
  logic [RW-1:0] den_top;

  assign magx    = numx_r[NW-1] ? NW'(-numx_r) : NW'(numx_r);
  assign magy    = numy_r[NW-1] ? NW'(-numy_r) : NW'(numy_r);
  assign den_top = RW'(den5_r) << QB;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vd_r[0] <= 1'b0;
    end else if (adv) begin
      vd_r[0] <= v5_r;
    end
    if (adv) begin
      remx_r[0] <= RW'(magx);
      remy_r[0] <= RW'(magy);
      qtx_r[0]  <= '0;
      qty_r[0]  <= '0;
      den_r[0]  <= den5_r;
      negx_r[0] <= numx_r[NW-1];
      negy_r[0] <= numy_r[NW-1];
      ovfx_r[0] <= RW'(magx) >= den_top;
      ovfy_r[0] <= RW'(magy) >= den_top;
      deg_r[0]  <= deg5_r;
    end
  end

  // restoring division, one quotient bit per stage
  for (genvar k = 0; k < QB; k++) begin : g_div
    logic [RW-1:0] sub;
    logic          gex, gey;

    assign sub = RW'(den_r[k]) << (QB - 1 - k);
    assign gex = remx_r[k] >= sub;
    assign gey = remy_r[k] >= sub;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vd_r[k+1] <= 1'b0;
      end else if (adv) begin
        vd_r[k+1] <= vd_r[k];
      end
      if (adv) begin
        remx_r[k+1] <= gex ? remx_r[k] - sub : remx_r[k];
        remy_r[k+1] <= gey ? remy_r[k] - sub : remy_r[k];
        qtx_r[k+1]  <= {qtx_r[k][QB-2:0], gex};
        qty_r[k+1]  <= {qty_r[k][QB-2:0], gey};
        den_r[k+1]  <= den_r[k];
        negx_r[k+1] <= negx_r[k];
        negy_r[k+1] <= negy_r[k];
        ovfx_r[k+1] <= ovfx_r[k];
        ovfy_r[k+1] <= ovfy_r[k];
        deg_r[k+1]  <= deg_r[k];
      end
    end
  end

  // output stage: sign, saturation, degenerate
  localparam logic [QB-1:0] FMAX = {1'b0, {(QB-1){1'b1}}};
  localparam logic [QB-1:0] FMIN = {1'b1, {(QB-1){1'b0}}};

  logic [QB-1:0] fx_nxt, fy_nxt;

  always_comb begin
    if (deg_r[QB]) begin
      fx_nxt = '0;
    end else if (negx_r[QB]) begin
      fx_nxt = (ovfx_r[QB] || qtx_r[QB] > FMIN) ? FMIN : QB'(-qtx_r[QB]);
    end else begin
      fx_nxt = (ovfx_r[QB] || qtx_r[QB][QB-1]) ? FMAX : qtx_r[QB];
    end
    if (deg_r[QB]) begin
      fy_nxt = '0;
    end else if (negy_r[QB]) begin
      fy_nxt = (ovfy_r[QB] || qty_r[QB] > FMIN) ? FMIN : QB'(-qty_r[QB]);
    end else begin
      fy_nxt = (ovfy_r[QB] || qty_r[QB][QB-1]) ? FMAX : qty_r[QB];
    end
  end

  logic          ov_r, odeg_r;
  logic [QB-1:0] ofx_r, ofy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (adv) begin
      ov_r <= vd_r[QB];
    end
    if (adv) begin
      ofx_r  <= fx_nxt;
      ofy_r  <= fy_nxt;
      odeg_r <= deg_r[QB];
    end
  end

  assign out_ch.valid      = ov_r;
  assign out_ch.foot_x     = ofx_r;
  assign out_ch.foot_y     = ofy_r;
  assign out_ch.degenerate = odeg_r;

endmodule

[rtl/core/pfp_checker.sv]
module pfp_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic signed [pfp_pkg::FOOT_BITS-1:0] out_foot_x,
  input logic signed [pfp_pkg::FOOT_BITS-1:0] out_foot_y,
  input logic                                out_degenerate
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped under stall");

  a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate |-> out_foot_x == '0 && out_foot_y == '0)
    else $error("degenerate result has nonzero foot");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

endmodule

bind perpendicular_foot_point pfp_checker u_pfp_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_foot_x     (out_ch.foot_x),
  .out_foot_y     (out_ch.foot_y),
  .out_degenerate (out_ch.degenerate)
);

[dv/perpendicular_foot_point_tb.sv]
`timescale 1ns / 1ps

module perpendicular_foot_point_tb;

  localparam int CB = pfp_pkg::COORD_BITS_DEF;
  localparam int FB = pfp_pkg::FOOT_BITS;
  localparam int N_RANDOM = 1400;
  localparam int IDLE_LIMIT = 20000;
  localparam int LATENCY = 25;

  typedef struct packed {
    logic signed [CB-1:0] ax, ay, bx, by, qx, qy;
  } query_t;

  typedef struct packed {
    logic signed [FB-1:0] fx, fy;
    logic                 degen;
  } foot_t;

  typedef struct {
    query_t q;
    logic   known;
    foot_t  f;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  pfp_in_if #(.COORD_BITS(CB)) in_ch ();
  pfp_out_if out_ch ();

  perpendicular_foot_point #(.COORD_BITS(CB)) u_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  foot_t  feet_due[$];
  int     errors = 0;
  int     idle_cycles = 0;
  logic   sending_done = 1'b0;
  int     stall_phase = 0;

  function automatic logic signed [FB-1:0] quot_sat(logic signed [127:0] num,
                                                     logic signed [127:0] den);
    logic signed [127:0] q;
    q = num / den;
    if (q > 128'sd131071) return 18'sd131071;
    if (q < -128'sd131072) return -18'sd131072;
    return q[FB-1:0];
  endfunction

  function automatic foot_t project_foot(query_t q);
    logic signed [127:0] dx, dy, c0, c1, den;
    foot_t r;
    dx = 128'(q.ax) - 128'(q.bx);
    dy = 128'(q.ay) - 128'(q.by);
    if (dx == 0 && dy == 0) begin
      r.fx = '0;
      r.fy = '0;
      r.degen = 1'b1;
      return r;
    end
    c0 = -dy * 128'(q.ax) + dx * 128'(q.ay);
    c1 = -dx * 128'(q.qx) - dy * 128'(q.qy);
    den = dx * dx + dy * dy;
    r.fx = quot_sat(-c1 * dx - c0 * dy, den);
    r.fy = quot_sat(c0 * dx - c1 * dy, den);
    r.degen = 1'b0;
    return r;
  endfunction

  function automatic query_t rand_query();
    query_t q;
    int mode;
    q = query_t'({$urandom, $urandom, $urandom});
    mode = $urandom_range(0, 9);
    if (mode == 0) begin
      q.bx = q.ax;
      q.by = q.ay;
    end else if (mode == 1) begin
      q.bx = q.ax + CB'($urandom_range(0, 4)) - CB'(2);
      q.by = q.ay + CB'($urandom_range(0, 4)) - CB'(2);
    end else if (mode == 2) begin
      q.bx = q.ax;
    end else if (mode == 3) begin
      q.by = q.ay;
    end
    return q;
  endfunction

  row_t rows[$];

  task automatic add_row(query_t q, logic known, foot_t f);
    row_t r;
    r.q = q;
    r.known = known;
    r.f = known ? f : project_foot(q);
    rows.push_back(r);
  endtask

  task automatic build_table();
    localparam logic signed [CB-1:0] MX = {1'b0, {(CB-1){1'b1}}};
    localparam logic signed [CB-1:0] MN = {1'b1, {(CB-1){1'b0}}};
    foot_t zero_degen, none;
    zero_degen = '{fx: '0, fy: '0, degen: 1'b1};
    none = '0;
    add_row('{ax: 0, ay: 0, bx: 0, by: 0, qx: 0, qy: 0}, 1, zero_degen);
    add_row('{ax: MX, ay: MN, bx: MX, by: MN, qx: MN, qy: MX}, 1, zero_degen);
    add_row('{ax: -1, ay: -1, bx: -1, by: -1, qx: 5, qy: 7}, 1, zero_degen);
    // horizontal line through origin: foot = (qx, 0)
    add_row('{ax: 0, ay: 0, bx: 10, by: 0, qx: 7, qy: 9}, 1,
            '{fx: 7, fy: 0, degen: 0});
    add_row('{ax: 0, ay: 0, bx: 0, by: 10, qx: 7, qy: -9}, 1,
            '{fx: 0, fy: -9, degen: 0});
    add_row('{ax: MN, ay: MN, bx: MX, by: MX, qx: MN, qy: MX}, 0, none);
    add_row('{ax: MX, ay: MN, bx: MN, by: MX, qx: MX, qy: MX}, 0, none);
    add_row('{ax: MN, ay: MX, bx: MX, by: MN, qx: MN, qy: MN}, 0, none);
    add_row('{ax: MX, ay: MX, bx: MX, by: MX - 1, qx: MN, qy: MN}, 0, none);
    add_row('{ax: MN, ay: 0, bx: MN + 1, by: 0, qx: MX, qy: MN}, 0, none);
    add_row('{ax: 0, ay: 0, bx: 1, by: 1, qx: 1, qy: 0}, 0, none);
    add_row('{ax: 0, ay: 0, bx: 1, by: 1, qx: -1, qy: 0}, 0, none);
    add_row('{ax: 3, ay: -2, bx: -7, by: 5, qx: 11, qy: 13}, 0, none);
    add_row('{ax: MN, ay: MN, bx: MX, by: MN, qx: MX, qy: MX}, 0, none);
    add_row('{ax: -1, ay: 0, bx: 0, by: -1, qx: MX, qy: MN}, 0, none);
    add_row('{ax: 12345, ay: -321, bx: -30000, by: 29999, qx: MN, qy: 1}, 0, none);
  endtask

  // sender
  initial begin
    int burst;
    query_t q;
    burst = 0;
    in_ch.valid <= 1'b0;
    {in_ch.line_a_x, in_ch.line_a_y, in_ch.line_b_x, in_ch.line_b_y,
     in_ch.query_x, in_ch.query_y} <= '0;
    build_table();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int i = 0; i < rows.size() + N_RANDOM; i++) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 40);
        if ($urandom_range(0, 2) != 0) begin
          in_ch.valid <= 1'b0;
          repeat ($urandom_range(1, 6)) @(posedge clk);
        end
      end
      burst--;
      if (i < rows.size()) q = rows[i].q;
      else q = rand_query();
      in_ch.valid    <= 1'b1;
      in_ch.line_a_x <= q.ax;
      in_ch.line_a_y <= q.ay;
      in_ch.line_b_x <= q.bx;
      in_ch.line_b_y <= q.by;
      in_ch.query_x  <= q.qx;
      in_ch.query_y  <= q.qy;
      do @(posedge clk); while (!in_ch.ready);
      if (i < rows.size()) feet_due.push_back(rows[i].f);
      else feet_due.push_back(project_foot(q));
    end
    in_ch.valid <= 1'b0;
    sending_done = 1'b1;
  end

  // receiver stall pattern: alternating free-running and choppy stretches
  always @(posedge clk) begin
    stall_phase <= (stall_phase + 1) % 300;
    if (stall_phase < 100) out_ch.ready <= 1'b1;
    else if (stall_phase < 200) out_ch.ready <= ($urandom_range(0, 3) != 0);
    else out_ch.ready <= ($urandom_range(0, 1) != 0);
  end

  initial out_ch.ready = 1'b0;

  always @(posedge clk) begin
    foot_t got, want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{fx: out_ch.foot_x, fy: out_ch.foot_y, degen: out_ch.degenerate};
      if (feet_due.size() == 0) begin
        $display("%0t: unexpected item fx=%0d fy=%0d degen=%0b", $time,
                 got.fx, got.fy, got.degen);
        errors++;
      end else begin
        want = feet_due.pop_front();
        if (got.fx !== want.fx) begin
          $display("%0t: foot_x expected %0d actual %0d", $time, want.fx, got.fx);
          errors++;
        end
        if (got.fy !== want.fy) begin
          $display("%0t: foot_y expected %0d actual %0d", $time, want.fy, got.fy);
          errors++;
        end
        if (got.degen !== want.degen) begin
          $display("%0t: degenerate expected %0b actual %0b", $time,
                   want.degen, got.degen);
          errors++;
        end
      end
    end
  end

  initial begin
    int tail;
    tail = 0;
    forever begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
      if (sending_done && feet_due.size() == 0) tail++;
      if (tail >= 4 * LATENCY) begin
        if (errors == 0) $display("RESULT: OK");
        else $display("RESULT: ERROR");
        $finish;
      end
    end
  end

endmodule
